>>> sv/sfcs_pkg.sv
// Shared types, constants and codes of the serial-flash command sequencer.
`default_nettype none
package sfcs_pkg;
  localparam int MAX_PAGE_BYTES_DEF = 528;
  localparam int ADDRESS_BITS_DEF   = 24;
  localparam int PS_W   = 10;
  localparam int AIN_W  = 24;
  localparam int CNT_W  = 11;
  localparam int PADDR_W = 4;

  localparam logic [PADDR_W-1:0] REG_PAGE_SIZE  = 4'h0;
  localparam logic [PADDR_W-1:0] REG_ADDR_SHIFT = 4'h4;
  localparam logic [PADDR_W-1:0] REG_WRITE_STY  = 4'h8;
  localparam logic [PADDR_W-1:0] REG_ERASE_STY  = 4'hC;

  localparam logic [2:0] K_ERASE  = 3'd0;
  localparam logic [2:0] K_PSTART = 3'd1;
  localparam logic [2:0] K_PDATA  = 3'd2;
  localparam logic [2:0] K_READ   = 3'd3;
  localparam logic [2:0] K_STATUS = 3'd4;
  localparam logic [2:0] K_PAD    = 3'd5;

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_BE    = 8'hD8;
  localparam logic [7:0] OP_PP    = 8'h02;
  localparam logic [7:0] OP_PPB   = 8'h82;
  localparam logic [7:0] OP_RDY   = 8'hD7;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] PAD_BYTE = 8'hFF;
  localparam logic [7:0] WIP_MASK = 8'h01;
  localparam logic [7:0] RDY_MASK = 8'h80;

  typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_PAD, PH_POLL} phase_t;

  // Byte source selected by the controller for one result.
  typedef enum logic [2:0] {
    SRC_NONE, SRC_CONST, SRC_A2, SRC_A1, SRC_A0, SRC_DATA
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_EMIT, ST_HOLD
  } st_t;

  // Controller to datapath.
  typedef struct packed {
    logic       div_start;
    logic       with_off;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_busy;
  } dp_stat_t;
endpackage
`default_nettype wire

>>> sv/sfcs_datapath.sv
// Address translation datapath: serial divider, shifter and address mask.
`default_nettype none
module sfcs_datapath #(
  parameter int ADDRESS_BITS = sfcs_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sfcs_pkg::dp_cmd_t         cmd,
  input  wire logic [sfcs_pkg::AIN_W-1:0] addr_in,
  input  wire logic [sfcs_pkg::PS_W-1:0] page_eff,
  input  wire logic [3:0]                shift_in,
  output sfcs_pkg::dp_stat_t             stat,
  output logic [23:0]                    dev_addr
);
  import sfcs_pkg::*;
  localparam int QW = AIN_W + 15;

  logic [AIN_W-1:0] quo_r, quo_nxt;
  logic [PS_W:0]    rem_r, rem_nxt;
  logic [4:0]       step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             off_r, off_nxt;
  logic [PS_W:0]    trial;
  logic [QW-1:0]    shifted;
  logic [ADDRESS_BITS-1:0] masked;

  // One quotient bit per cycle, restoring division.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    off_nxt = off_r;
    trial = {rem_r[PS_W-1:0], quo_r[AIN_W-1]};
    if (cmd.div_start) begin
      quo_nxt = addr_in;
      rem_nxt = '0;
      step_nxt = 5'(AIN_W);
      busy_nxt = 1'b1;
      off_nxt = cmd.with_off;
    end else if (busy_r) begin
      if (trial >= {1'b0, page_eff}) begin
        rem_nxt = trial - {1'b0, page_eff};
        quo_nxt = {quo_r[AIN_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[AIN_W-2:0], 1'b0};
      end
      step_nxt = step_r - 5'd1;
      if (step_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    off_r <= off_nxt;
  end

  // Page number shifted into place, offset merged for reads, then masked.
  always_comb begin
    shifted = {15'd0, quo_r} << shift_in;
    if (off_r) shifted = shifted | QW'(rem_r);
    masked = shifted[ADDRESS_BITS-1:0];
    dev_addr = 24'(masked);
  end

  assign stat.div_busy = busy_r;
endmodule
`default_nettype wire

>>> sv/sfcs_ctrl.sv
// Sequencing controller: phase tracking and result framing.
`default_nettype none
module sfcs_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 in_kind,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_data_last,
  input  wire logic [23:0]                in_read_length,
  input  wire logic [sfcs_pkg::PS_W-1:0]  page_eff,
  input  wire logic                       write_style,
  input  wire logic                       erase_style,
  output sfcs_pkg::dp_cmd_t               cmd,
  input  wire sfcs_pkg::dp_stat_t         stat,
  input  wire logic [23:0]                dev_addr,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_spi_byte,
  output logic                            out_byte_valid,
  output logic                            out_end_of_frame,
  output logic [23:0]                     out_read_count,
  output logic                            out_op_done,
  output logic                            out_rejected,
  output logic                            out_last_result
);
  import sfcs_pkg::*;

  // A step is a short list of result slots built at acceptance.
  typedef struct packed {
    src_t       src;
    logic [7:0] cbyte;
    logic       eof;
    logic [1:0] rc;     // 0 none, 1 one, 2 read length
    logic       done;
    logic       rej;
  } slot_t;

  st_t              st_r, st_nxt;
  phase_t           phase_r, phase_nxt;
  logic             poll_r, poll_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  slot_t [5:0]      sl_r, sl_nxt;
  logic [2:0]       n_r, n_nxt, idx_r, idx_nxt;
  logic [7:0]       db_r, db_nxt;
  logic [23:0]      rlen_r, rlen_nxt;
  slot_t            cur;
  logic             acc, take, busy_st;
  logic [CNT_W-1:0] cinc;
  logic [7:0]       pb;

  function automatic slot_t mk(src_t s, logic [7:0] b, logic e, logic [1:0] r,
                               logic d, logic j);
    slot_t t;
    t.src = s; t.cbyte = b; t.eof = e; t.rc = r; t.done = d; t.rej = j;
    return t;
  endfunction

  assign in_stall = (st_r != ST_IDLE);
  assign acc = in_valid && !in_stall;
  assign cur = sl_r[idx_r];
  assign take = out_valid && !out_stall;
  assign out_valid = (st_r == ST_EMIT);

  // Next state, step framing and command to the datapath.
  always_comb begin
    st_nxt = st_r; phase_nxt = phase_r; poll_nxt = poll_r; cnt_nxt = cnt_r;
    sl_nxt = sl_r; n_nxt = n_r; idx_nxt = idx_r; db_nxt = db_r; rlen_nxt = rlen_r;
    cmd = '0;
    busy_st = 1'b0;
    cinc = cnt_r + CNT_W'(1);
    pb = (in_kind == K_PAD) ? PAD_BYTE : in_data_byte;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          idx_nxt = '0;
          db_nxt = pb;
          rlen_nxt = in_read_length;
          st_nxt = ST_EMIT;
          sl_nxt[0] = mk(SRC_NONE, 8'h00, 1'b0, 2'd0, 1'b0, 1'b1);
          n_nxt = 3'd1;
          if (in_kind == K_ERASE && phase_r == PH_IDLE) begin
            if (erase_style) begin
              sl_nxt[0] = mk(SRC_CONST, OP_WREN, 1'b1, 2'd0, 1'b0, 1'b0);
              sl_nxt[1] = mk(SRC_CONST, OP_BE, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[2] = mk(SRC_A2, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[3] = mk(SRC_A1, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[4] = mk(SRC_A0, 8'h00, 1'b1, 2'd0, 1'b0, 1'b0);
              sl_nxt[5] = mk(SRC_CONST, OP_RDSR, 1'b1, 2'd1, 1'b0, 1'b0);
              n_nxt = 3'd6;
              poll_nxt = 1'b0;
              phase_nxt = PH_POLL;
              cmd.div_start = 1'b1;
              st_nxt = ST_DIV;
            end else begin
              sl_nxt[0] = mk(SRC_NONE, 8'h00, 1'b0, 2'd0, 1'b1, 1'b0);
            end
          end else if (in_kind == K_PSTART && phase_r == PH_IDLE) begin
            if (write_style) begin
              sl_nxt[0] = mk(SRC_CONST, OP_PPB, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[1] = mk(SRC_A2, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[2] = mk(SRC_A1, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[3] = mk(SRC_A0, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              n_nxt = 3'd4;
            end else begin
              sl_nxt[0] = mk(SRC_CONST, OP_WREN, 1'b1, 2'd0, 1'b0, 1'b0);
              sl_nxt[1] = mk(SRC_CONST, OP_PP, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[2] = mk(SRC_A2, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[3] = mk(SRC_A1, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              sl_nxt[4] = mk(SRC_A0, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              n_nxt = 3'd5;
            end
            poll_nxt = write_style;
            cnt_nxt = '0;
            phase_nxt = PH_DATA;
            cmd.div_start = 1'b1;
            st_nxt = ST_DIV;
          end else if (in_kind == K_READ && phase_r == PH_IDLE) begin
            sl_nxt[0] = mk(SRC_CONST, OP_READ, 1'b0, 2'd0, 1'b0, 1'b0);
            sl_nxt[1] = mk(SRC_A2, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
            sl_nxt[2] = mk(SRC_A1, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
            sl_nxt[3] = mk(SRC_A0, 8'h00, 1'b1, 2'd2, 1'b1, 1'b0);
            n_nxt = 3'd4;
            cmd.div_start = 1'b1;
            cmd.with_off = 1'b1;
            st_nxt = ST_DIV;
          end else if (in_kind == K_STATUS && phase_r == PH_POLL) begin
            busy_st = poll_r ? ((in_data_byte & RDY_MASK) == 8'h00)
                             : ((in_data_byte & WIP_MASK) != 8'h00);
            if (busy_st) begin
              sl_nxt[0] = mk(SRC_CONST, poll_r ? OP_RDY : OP_RDSR, 1'b1, 2'd1,
                             1'b0, 1'b0);
            end else begin
              sl_nxt[0] = mk(SRC_NONE, 8'h00, 1'b0, 2'd0, 1'b1, 1'b0);
              phase_nxt = PH_IDLE;
            end
          end else if ((in_kind == K_PDATA && phase_r == PH_DATA) ||
                       (in_kind == K_PAD &&
                        (phase_r == PH_DATA || phase_r == PH_PAD))) begin
            cnt_nxt = cinc;
            if (cinc >= CNT_W'(page_eff)) begin
              sl_nxt[0] = mk(SRC_DATA, 8'h00, 1'b1, 2'd0, 1'b0, 1'b0);
              sl_nxt[1] = mk(SRC_CONST, poll_r ? OP_RDY : OP_RDSR, 1'b1, 2'd1,
                             1'b0, 1'b0);
              n_nxt = 3'd2;
              phase_nxt = PH_POLL;
            end else begin
              sl_nxt[0] = mk(SRC_DATA, 8'h00, 1'b0, 2'd0, 1'b0, 1'b0);
              if (in_kind == K_PAD || in_data_last) phase_nxt = PH_PAD;
            end
          end
        end
      end
      ST_DIV: begin
        if (!stat.div_busy) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (take) begin
          if (idx_r == n_r - 3'd1) st_nxt = ST_IDLE;
          else idx_nxt = idx_r + 3'd1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      phase_r <= PH_IDLE;
      poll_r <= 1'b0;
      cnt_r <= '0;
      idx_r <= '0;
      n_r <= 3'd1;
    end else begin
      st_r <= st_nxt;
      phase_r <= phase_nxt;
      poll_r <= poll_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      n_r <= n_nxt;
    end
    sl_r <= sl_nxt;
    db_r <= db_nxt;
    rlen_r <= rlen_nxt;
  end

  // Result fields for the current slot.
  always_comb begin
    case (cur.src)
      SRC_CONST: out_spi_byte = cur.cbyte;
      SRC_A2:    out_spi_byte = dev_addr[23:16];
      SRC_A1:    out_spi_byte = dev_addr[15:8];
      SRC_A0:    out_spi_byte = dev_addr[7:0];
      SRC_DATA:  out_spi_byte = db_r;
      default:   out_spi_byte = 8'h00;
    endcase
    out_byte_valid = (cur.src != SRC_NONE);
    out_end_of_frame = cur.eof;
    case (cur.rc)
      2'd1:    out_read_count = 24'd1;
      2'd2:    out_read_count = rlen_r;
      default: out_read_count = 24'd0;
    endcase
    out_op_done = cur.done;
    out_rejected = cur.rej;
    out_last_result = (idx_r == n_r - 3'd1);
  end

  // A reject never carries a bus byte.
  a_rej_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_byte_valid && out_last_result)
    else $error("reject result carries a byte");
  // Input is only taken when nothing is pending.
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while results pending");
  // The divider is finished whenever a result is shown.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !stat.div_busy) else $error("result shown mid-division");
endmodule
`default_nettype wire

>>> sv/spi_flash_command_sequencer.sv
// Top level of the serial-flash command sequencer with its register file.
`default_nettype none
// Turns erase, page-program and read requests into SPI byte frames, one byte or
// marker per output transaction. An item is taken only once every result of the
// previous item has been delivered. Program start, read and erase (with the
// erase style set) run a one-bit-per-clock divider over the 24-bit address
// before their results, up to six, are shown. Registers sit at byte
// addresses 0, 4, 8, 12.
module spi_flash_command_sequencer #(
  parameter int MAX_PAGE_BYTES = sfcs_pkg::MAX_PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS   = sfcs_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [23:0] in_address,
  input  wire logic [23:0] in_read_length,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_data_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_spi_byte,
  output logic             out_byte_valid,
  output logic             out_end_of_frame,
  output logic [23:0]      out_read_count,
  output logic             out_op_done,
  output logic             out_rejected,
  output logic             out_last_result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [sfcs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sfcs_pkg::*;

  logic [PS_W-1:0] page_size_r;
  logic [3:0]      shift_r;
  logic            wstyle_r, estyle_r;
  logic [PS_W-1:0] page_eff;
  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [23:0]     dev_addr;

  assign pready = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= PS_W'(256);
      shift_r <= 4'd8;
      wstyle_r <= 1'b0;
      estyle_r <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_PAGE_SIZE:  page_size_r <= pwdata[PS_W-1:0];
        REG_ADDR_SHIFT: shift_r <= pwdata[3:0];
        REG_WRITE_STY:  wstyle_r <= pwdata[0];
        REG_ERASE_STY:  estyle_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_PAGE_SIZE:  prdata = 32'(page_size_r);
      REG_ADDR_SHIFT: prdata = 32'(shift_r);
      REG_WRITE_STY:  prdata = 32'(wstyle_r);
      REG_ERASE_STY:  prdata = 32'(estyle_r);
      default:        prdata = 32'd0;
    endcase
  end

  // Effective page size: zero means one, large values are clamped.
  always_comb begin
    if (page_size_r == '0) page_eff = PS_W'(1);
    else if (32'(page_size_r) > MAX_PAGE_BYTES) page_eff = PS_W'(MAX_PAGE_BYTES);
    else page_eff = page_size_r;
  end

  sfcs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_data_byte, .in_data_last,
    .in_read_length, .page_eff, .write_style(wstyle_r), .erase_style(estyle_r),
    .cmd, .stat, .dev_addr, .out_valid, .out_stall, .out_spi_byte, .out_byte_valid,
    .out_end_of_frame, .out_read_count, .out_op_done, .out_rejected,
    .out_last_result
  );

  sfcs_datapath #(.ADDRESS_BITS(ADDRESS_BITS)) u_dp (
    .clk, .rst_n, .cmd, .addr_in(in_address), .page_eff, .shift_in(shift_r),
    .stat, .dev_addr
  );
endmodule
`default_nettype wire

>>> tb/sv/spi_flash_command_sequencer_test.sv
// Self-checking testbench for the serial-flash command sequencer.
`timescale 1ns / 100ps
`default_nettype none
module spi_flash_command_sequencer_test;
  import sfcs_pkg::*;

  // One output transaction of the block.
  typedef struct packed {
    logic [7:0]  spi_byte;
    logic        byte_valid;
    logic        eof;
    logic [23:0] read_count;
    logic        op_done;
    logic        rejected;
    logic        last;
  } frame_byte_t;

  // Predicts the bus bytes of each accepted request and checks them in order.
  class frame_scoreboard;
    logic [9:0]  page_size_r;
    logic [3:0]  shift_r;
    logic        write_style_r;
    logic        erase_style_r;
    phase_t      ph;
    logic        poll_ready;
    logic [10:0] page_count;
    frame_byte_t pending_bytes[$];
    int          mismatches;

    function new();
      page_size_r = 10'd256;
      shift_r = 4'd8;
      write_style_r = 1'b0;
      erase_style_r = 1'b1;
      ph = PH_IDLE;
      poll_ready = 1'b0;
      page_count = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [3:0] addr, logic [31:0] value);
      case (addr)
        REG_PAGE_SIZE: page_size_r = value[9:0];
        REG_ADDR_SHIFT: shift_r = value[3:0];
        REG_WRITE_STY: write_style_r = value[0];
        REG_ERASE_STY: erase_style_r = value[0];
        default: ;
      endcase
    endfunction

    function int eff_page();
      int p;
      p = page_size_r;
      if (p == 0) p = 1;
      if (p > MAX_PAGE_BYTES_DEF) p = MAX_PAGE_BYTES_DEF;
      return p;
    endfunction

    function logic [23:0] device_address(logic [23:0] a, bit with_off);
      longint unsigned pn, d;
      pn = a / eff_page();
      d = pn << shift_r;
      if (with_off) d = d | (a % eff_page());
      return d[23:0];
    endfunction

    function void push(logic [7:0] b, logic v, logic eof, logic [23:0] rc,
                       logic done, logic rej);
      frame_byte_t f;
      f = '{b, v, eof, rc, done, rej, 1'b0};
      pending_bytes.push_back(f);
    endfunction

    function void push_addr(logic [23:0] a, logic eof, logic [23:0] rc, logic done);
      push(a[23:16], 1, 0, 0, 0, 0);
      push(a[15:8], 1, 0, 0, 0, 0);
      push(a[7:0], 1, eof, rc, done, 0);
    endfunction

    function void push_poll();
      push(poll_ready ? OP_RDY : OP_RDSR, 1, 1, 24'd1, 0, 0);
    endfunction

    function void page_byte(logic [7:0] b);
      page_count = page_count + 1;
      if (page_count >= eff_page()) begin
        push(b, 1, 1, 0, 0, 0);
        push_poll();
        ph = PH_POLL;
      end else begin
        push(b, 1, 0, 0, 0, 0);
      end
    endfunction

    // Notes one accepted request and queues the bytes it should produce.
    function void note_request(logic [2:0] kind, logic [23:0] addr, logic [23:0] rlen,
                               logic [7:0] db, logic dlast);
      int n0;
      bit busy;
      n0 = pending_bytes.size();
      if (kind == K_ERASE && ph == PH_IDLE) begin
        if (erase_style_r) begin
          push(OP_WREN, 1, 1, 0, 0, 0);
          push(OP_BE, 1, 0, 0, 0, 0);
          push_addr(device_address(addr, 0), 1, 0, 0);
          poll_ready = 1'b0;
          push_poll();
          ph = PH_POLL;
        end else begin
          push(8'h00, 0, 0, 0, 1, 0);
        end
      end else if (kind == K_PSTART && ph == PH_IDLE) begin
        if (write_style_r) begin
          push(OP_PPB, 1, 0, 0, 0, 0);
        end else begin
          push(OP_WREN, 1, 1, 0, 0, 0);
          push(OP_PP, 1, 0, 0, 0, 0);
        end
        push_addr(device_address(addr, 0), 0, 0, 0);
        poll_ready = write_style_r;
        page_count = '0;
        ph = PH_DATA;
      end else if (kind == K_PDATA && ph == PH_DATA) begin
        page_byte(db);
        if (ph == PH_DATA && dlast) ph = PH_PAD;
      end else if (kind == K_READ && ph == PH_IDLE) begin
        push(OP_READ, 1, 0, 0, 0, 0);
        push_addr(device_address(addr, 1), 1, rlen, 1);
      end else if (kind == K_STATUS && ph == PH_POLL) begin
        busy = poll_ready ? ((db & RDY_MASK) == 0) : ((db & WIP_MASK) != 0);
        if (busy) begin
          push_poll();
        end else begin
          push(8'h00, 0, 0, 0, 1, 0);
          ph = PH_IDLE;
        end
      end else if (kind == K_PAD && (ph == PH_DATA || ph == PH_PAD)) begin
        ph = PH_PAD;
        page_byte(PAD_BYTE);
      end else begin
        push(8'h00, 0, 0, 0, 0, 1);
      end
      pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      if (pending_bytes.size() <= n0) $display("internal: no prediction");
    endfunction

    // Compares one delivered byte with the oldest prediction.
    function void check_byte(frame_byte_t got);
      frame_byte_t exp_b;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction %p", got);
        return;
      end
      exp_b = pending_bytes.pop_front();
      if (got !== exp_b) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_b, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = '0;
  logic [23:0] in_address = '0;
  logic [23:0] in_read_length = '0;
  logic [7:0] in_data_byte = '0;
  logic in_data_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [7:0] out_spi_byte;
  logic out_byte_valid, out_end_of_frame, out_op_done, out_rejected, out_last_result;
  logic [23:0] out_read_count;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  frame_scoreboard sb;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  spi_flash_command_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_address(in_address), .in_read_length(in_read_length),
    .in_data_byte(in_data_byte), .in_data_last(in_data_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_spi_byte(out_spi_byte),
    .out_byte_valid(out_byte_valid), .out_end_of_frame(out_end_of_frame),
    .out_read_count(out_read_count), .out_op_done(out_op_done),
    .out_rejected(out_rejected), .out_last_result(out_last_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Collects output transactions and drives the receiver's stall.
  initial begin : result_side
    int wait_cycles;
    frame_byte_t got;
    wait_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = '{out_spi_byte, out_byte_valid, out_end_of_frame, out_read_count,
                out_op_done, out_rejected, out_last_result};
        sb.check_byte(got);
      end
      if (hold_long) begin
        out_stall <= 1'b1;
      end else if (wait_cycles > 0) begin
        wait_cycles--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0 && !stim_done) begin
        wait_cycles = gap_len();
        out_stall <= (wait_cycles > 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Writes one register through the configuration port.
  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(addr, value);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offers one request and waits until the block takes it.
  task automatic send_request(logic [2:0] kind, logic [23:0] addr, logic [23:0] rlen,
                              logic [7:0] db, logic dlast, bit idle_gaps);
    int g;
    g = idle_gaps ? gap_len() : 0;
    // The previous request drops valid at its accepting edge; drive the next one later.
    @(posedge clk);
    repeat (g) @(posedge clk);
    in_valid <= 1'b1; in_kind <= kind; in_address <= addr;
    in_read_length <= rlen; in_data_byte <= db; in_data_last <= dlast;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, addr, rlen, db, dlast);
    in_valid <= 1'b0;
  endtask

  // Waits until every predicted byte has arrived, plus a margin for divider work.
  task automatic drain();
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_random(bit idle_gaps);
    send_request($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, idle_gaps);
  endtask

  // One full page program with random content, then a poll sequence.
  task automatic program_sequence(bit idle_gaps);
    int nd, np, ps;
    ps = sb.eff_page();
    nd = $urandom_range(0, 5);
    np = $urandom_range(0, 4);
    send_request(K_PSTART, $urandom, $urandom, $urandom, 0, idle_gaps);
    for (int i = 0; i < nd; i++)
      send_request(K_PDATA, $urandom, $urandom, $urandom, i == nd - 1, idle_gaps);
    while (sb.ph == PH_DATA || sb.ph == PH_PAD) begin
      if (np > 0) begin
        np--;
        send_random(idle_gaps);
      end else begin
        send_request(K_PAD, $urandom, $urandom, $urandom, $urandom, idle_gaps);
      end
    end
    while (sb.ph == PH_POLL)
      send_request(K_STATUS, $urandom, $urandom, $urandom, $urandom, idle_gaps);
    if (ps < 0) $display("bad page");
  endtask

  // Configuration settings visited between phases.
  task automatic configure(int sel);
    case (sel)
      0: begin
        write_reg(REG_PAGE_SIZE, 1); write_reg(REG_ADDR_SHIFT, 0);
        write_reg(REG_WRITE_STY, 1); write_reg(REG_ERASE_STY, 0);
      end
      1: begin
        write_reg(REG_PAGE_SIZE, 0); write_reg(REG_ADDR_SHIFT, 15);
        write_reg(REG_WRITE_STY, 0); write_reg(REG_ERASE_STY, 1);
      end
      2: begin
        write_reg(REG_PAGE_SIZE, 13); write_reg(REG_ADDR_SHIFT, 9);
      end
      default: begin
        write_reg(REG_PAGE_SIZE, $urandom_range(2, 12));
        write_reg(REG_ADDR_SHIFT, $urandom_range(0, 15));
        write_reg(REG_WRITE_STY, $urandom_range(0, 1));
        write_reg(REG_ERASE_STY, $urandom_range(0, 1));
      end
    endcase
  endtask

  initial begin : stimulus
    int n;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: reads, erases, stray data and status, unknown kinds, wrong phases and extremes.
    send_request(K_READ, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1, 0);
    send_request(K_READ, 24'h000000, 24'h000000, 8'h00, 0, 0);
    send_request(K_PDATA, 24'h1, 0, 8'hAA, 1, 0);
    send_request(K_STATUS, 0, 0, 8'h00, 0, 0);
    send_request(3'd6, 0, 0, 0, 0, 0);
    send_request(3'd7, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1, 0);
    send_request(K_ERASE, 24'hFFFFFF, 0, 0, 0, 0);
    send_request(K_ERASE, 0, 0, 0, 0, 0);
    send_request(K_STATUS, 0, 0, 8'h01, 0, 0);
    send_request(K_STATUS, 0, 0, 8'hFE, 0, 0);
    drain();
    // An oversized page size is clamped to the largest page.
    write_reg(REG_PAGE_SIZE, 10'h3FF);
    send_request(K_READ, 24'hFFFFFF, 24'h000010, 0, 0, 0);
    send_request(K_ERASE, 24'h00ABCD, 0, 0, 0, 0);
    send_request(K_STATUS, 0, 0, 8'h00, 0, 0);
    drain();
    write_reg(REG_PAGE_SIZE, 4);
    // Data after last, then page full with data beyond the page rejected.
    send_request(K_PSTART, 24'h123456, 0, 0, 0, 0);
    send_request(K_PDATA, 0, 0, 8'h00, 1, 0);
    send_request(K_PDATA, 0, 0, 8'h11, 0, 0);
    send_request(K_PAD, 0, 0, 0, 0, 0);
    send_request(K_PAD, 0, 0, 0, 0, 0);
    send_request(K_PAD, 0, 0, 0, 0, 0);
    send_request(K_PDATA, 0, 0, 8'h22, 0, 0);
    send_request(K_STATUS, 0, 0, 8'h00, 0, 0);
    drain();
    // Ready-poll style, latched at start despite a style change mid-operation.
    write_reg(REG_WRITE_STY, 1);
    send_request(K_PSTART, 24'h000777, 0, 0, 0, 0);
    drain();
    write_reg(REG_WRITE_STY, 0);
    send_request(K_PAD, 0, 0, 0, 0, 0);
    send_request(K_PAD, 0, 0, 0, 0, 0);
    send_request(K_PAD, 0, 0, 0, 0, 0);
    send_request(K_PAD, 0, 0, 0, 0, 0);
    send_request(K_STATUS, 0, 0, 8'h7F, 0, 0);
    send_request(K_STATUS, 0, 0, 8'h80, 0, 0);
    drain();

    // Random part across several settings.
    n = 0;
    for (int cfg = 0; cfg < 6; cfg++) begin
      configure(cfg);
      for (int j = 0; j < 6; j++) begin
        case ($urandom_range(0, 5))
          0, 1, 2: program_sequence(1);
          3: begin
            send_request(K_ERASE, $urandom, $urandom, $urandom, $urandom, 1);
            while (sb.ph == PH_POLL)
              send_request(K_STATUS, $urandom, $urandom, $urandom, $urandom, 1);
          end
          4: send_request(K_READ, $urandom, $urandom, $urandom, $urandom, 1);
          default: send_random(1);
        endcase
        if (cfg == 3 && j == 2) begin
          // Hold the receiver off for a long stretch while requests keep coming.
          fork
            begin
              hold_long = 1'b1;
              repeat (300) @(posedge clk);
              hold_long = 1'b0;
            end
            repeat (4) send_request(K_READ, $urandom, $urandom, $urandom, 0, 0);
          join
        end
      end
      while (sb.ph == PH_DATA || sb.ph == PH_PAD)
        send_request(K_PAD, 0, 0, 0, 0, 1);
      while (sb.ph == PH_POLL)
        send_request(K_STATUS, 0, 0, $urandom, 0, 1);
      drain();
    end

    stim_done = 1'b1;
    drain();
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("spi_flash_command_sequencer_test: clean");
    end else begin
      $display("spi_flash_command_sequencer_test: errors");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin : watchdog
    #40ms;
    $display("spi_flash_command_sequencer_test: errors");
    $finish;
  end
endmodule
`default_nettype wire
